// ===== rtl/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// wts_pkg
// Shared constants and types of the weighted table sampler.
// ----------------------------------------------------------------------------
package wts_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int WEIGHT_WIDTH    = 32;
    localparam int KIND_W          = 2;
    localparam int VALUE_W         = 32;
    localparam int WORD_W          = 32;
    localparam int CUM_W           = 40;
    localparam int INDEX_W         = 8;

    localparam logic [WORD_W-1:0] WEIGHT_MASK = WORD_W'((64'd1 << WEIGHT_WIDTH) - 64'd1);

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SEARCH,
        ST_RESULT
    } wts_state_t;

endpackage

// ===== rtl/wts_if.sv =====
// ----------------------------------------------------------------------------
// wts_if
// Item and result channels of the weighted table sampler.
// ----------------------------------------------------------------------------
interface wts_item_if;
    import wts_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] entry_value;
    logic [WORD_W-1:0]         entry_weight;
    logic [WORD_W-1:0]         random_word;

    modport source (output valid, kind, entry_value, entry_weight, random_word,
                    input ready);
    modport sink   (input valid, kind, entry_value, entry_weight, random_word,
                    output ready);
endinterface

interface wts_result_if;
    import wts_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sample_value;
    logic [INDEX_W-1:0]        chosen_index;
    logic                      table_empty;

    modport source (output valid, sample_value, chosen_index, table_empty,
                    input ready);
    modport sink   (input valid, sample_value, chosen_index, table_empty,
                    output ready);
endinterface

// ===== rtl/weighted_table_sampler.sv =====
// ----------------------------------------------------------------------------
// weighted_table_sampler
// Keeps a table of value and weight pairs and draws entries by inverse
// cumulative weight, one index bit per cell of a search chain.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  item      in    kind, entry_value, entry_weight, random_word
//  result    out   sample_value, chosen_index, table_empty (sample beats only)
//
//  Clear and load beats take effect when accepted. A sample beat passes the
//  scaling multiply, the add, each cell of the chain in turn and a value
//  read before its result is registered; an empty table skips the chain.
//  One item is in work at a time; a stalled result holds the block once
//  the next sample is done. Reset empties the table at once.
// ----------------------------------------------------------------------------
module weighted_table_sampler #(
    parameter int TABLE_DEPTH = wts_pkg::TABLE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    wts_item_if.sink     item,
    wts_result_if.source result
);
    import wts_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = AW + 1;

    wts_state_t state_reg;
    wts_state_t state_next;

    logic [CW-1:0]      count_reg;
    logic [CUM_W-1:0]   total_reg;
    logic [63:0]        prod_lo_reg;
    logic [CUM_W-1:0]   prod_hi_reg;
    logic               empty_reg;
    logic [AW-1:0]      idx_reg;
    logic [VALUE_W-1:0] vrd_reg;
    logic [VALUE_W-1:0] value_mem [TABLE_DEPTH];

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [INDEX_W-1:0]        out_index_reg;
    logic                      out_empty_reg;

    logic             accept;
    logic             load_go;
    logic             launch;
    logic             out_load;
    logic [CUM_W-1:0] weight;
    logic [CUM_W:0]   tsum;
    logic [CUM_W-1:0] new_total;
    logic [AW-1:0]    sel_idx;

    logic             c_valid [AW+1];
    logic [AW-1:0]    c_pos   [AW+1];
    logic [CUM_W-1:0] c_u     [AW+1];

    assign accept  = item.valid && item.ready;
    assign load_go = accept && (item.kind == KIND_LOAD) && (count_reg < CW'(TABLE_DEPTH));

    // Saturating running sum of the masked weights.
    assign weight    = CUM_W'(item.entry_weight & WEIGHT_MASK);
    assign tsum      = {1'b0, total_reg} + {1'b0, weight};
    assign new_total = tsum[CUM_W] ? {CUM_W{1'b1}} : tsum[CUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item.ready = 1'b0;
        launch     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid && (item.kind == KIND_SAMPLE))
                begin
                    state_next = (count_reg == '0) ? ST_RESULT : ST_ADD;
                end
            end
            ST_ADD:
            begin
                launch     = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (c_valid[AW])
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end else if (accept && (item.kind == KIND_CLEAR))
        begin
            count_reg <= '0;
            total_reg <= '0;
        end else if (load_go)
        begin
            count_reg <= count_reg + CW'(1);
            total_reg <= new_total;
        end
    end

    // Scale the random word by the total: r * t_hi + (r * t_lo) >> 32.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_lo_reg <= 64'(item.random_word) * 64'(total_reg[31:0]);
            prod_hi_reg <= CUM_W'(item.random_word) * CUM_W'(total_reg[CUM_W-1:32]);
            empty_reg   <= (count_reg == '0);
        end
    end

    assign c_valid[0] = launch;
    assign c_pos[0]   = '0;
    assign c_u[0]     = prod_hi_reg + CUM_W'(prod_lo_reg[63:32]);

    genvar k;
    generate
        for (k = 0; k < AW; k++) begin : g_chain
            wts_cell #(
                .AW    (AW),
                .CW    (CW),
                .LEVEL (AW - 1 - k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (load_go),
                .wr_index  (count_reg[AW-1:0]),
                .wr_data   (new_total),
                .count     (count_reg),
                .in_valid  (c_valid[k]),
                .in_pos    (c_pos[k]),
                .in_u      (c_u[k]),
                .out_valid (c_valid[k+1]),
                .out_pos   (c_pos[k+1]),
                .out_u     (c_u[k+1])
            );
        end
    endgenerate

    // Fall back to the last entry when no cumulative weight exceeds u.
    assign sel_idx = ({1'b0, c_pos[AW]} == PW'(count_reg))
                   ? AW'(count_reg - CW'(1)) : c_pos[AW];

    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            value_mem[count_reg[AW-1:0]] <= item.entry_value;
        end
        if ((state_reg == ST_SEARCH) && c_valid[AW])
        begin
            vrd_reg <= value_mem[sel_idx];
            idx_reg <= sel_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= empty_reg ? '0 : vrd_reg;
            out_index_reg <= empty_reg ? '0 : INDEX_W'(idx_reg);
            out_empty_reg <= empty_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.sample_value = out_value_reg;
    assign result.chosen_index = out_index_reg;
    assign result.table_empty  = out_empty_reg;

endmodule

// ===== rtl/wts_cell.sv =====
// ----------------------------------------------------------------------------
// wts_cell
// One level of the search chain: holds the cumulative weights probed at this
// level and decides one bit of the chosen index.
// ----------------------------------------------------------------------------
module wts_cell #(
    parameter int AW    = 8,
    parameter int CW    = 9,
    parameter int LEVEL = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_index,
    input  logic [wts_pkg::CUM_W-1:0] wr_data,
    input  logic [CW-1:0]             count,
    input  logic                      in_valid,
    input  logic [AW-1:0]             in_pos,
    input  logic [wts_pkg::CUM_W-1:0] in_u,
    output logic                      out_valid,
    output logic [AW-1:0]             out_pos,
    output logic [wts_pkg::CUM_W-1:0] out_u
);
    import wts_pkg::*;

    localparam int PW = AW + 1;
    // Entries of this level have exactly LEVEL trailing ones in their index.
    localparam logic [AW-1:0] LOW_MASK = AW'((1 << (LEVEL + 1)) - 1);
    localparam logic [AW-1:0] ONES     = AW'((1 << LEVEL) - 1);
    localparam logic [AW-1:0] STEP     = AW'(1 << LEVEL);

    logic             valid_reg;
    logic [AW-1:0]    pos_reg;
    logic [CUM_W-1:0] u_reg;
    logic [CUM_W-1:0] rd_reg;
    logic             wr_hit;
    logic [AW-1:0]    probe;
    logic             take;

    assign wr_hit = wr_en && ((wr_index & LOW_MASK) == ONES);

    generate
        if (LEVEL == AW - 1) begin : g_single
            logic [CUM_W-1:0] key_reg;

            always_ff @(posedge clk)
            begin
                if (wr_hit)
                begin
                    key_reg <= wr_data;
                end
                rd_reg <= key_reg;
            end
        end else begin : g_bank
            localparam int DEPTH_L = 1 << (AW - 1 - LEVEL);
            logic [CUM_W-1:0] mem [DEPTH_L];

            always_ff @(posedge clk)
            begin
                if (wr_hit)
                begin
                    mem[wr_index[AW-1:LEVEL+1]] <= wr_data;
                end
                rd_reg <= mem[in_pos[AW-1:LEVEL+1]];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= in_pos;
        u_reg   <= in_u;
    end

    // Step past this probe when it lies in the table and does not exceed u.
    assign probe = pos_reg | ONES;
    assign take  = (PW'(probe) < PW'(count)) && (rd_reg <= u_reg);

    assign out_valid = valid_reg;
    assign out_pos   = take ? (pos_reg | STEP) : pos_reg;
    assign out_u     = u_reg;

endmodule
